/* design/tsps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsps_pkg: shared types and constants for the three-step phase shift block
// Widths of samples and results, the CORDIC arctangent table and the item
// that travels from the front end to the CORDIC back end.
// ----------------------------------------------------------------------------
package tsps_pkg;

	localparam int SAMPLE_W         = 8;
	localparam int PHASE_W          = 16;
	// cordic datapath width: |x|,|y| grow to about 8.4e6 * 1.65, under 2^25
	localparam int XW               = 26;
	// angle accumulator, 2^32 units per turn
	localparam int ZW               = 32;
	localparam int ATAN_ENTRIES     = 24;
	localparam int DEF_ANGLE_BITS   = 16;
	localparam int DEF_CORDIC_STEPS = 16;

	// sqrt3 in Q1.14
	localparam logic [15:0] SQRT3_Q14 = 16'd28378;
	localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

	// pre-rotated vector handed from front to back
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic                 half;
		logic                 zero;
	} front_item_t;

	localparam int ITEM_W = $bits(front_item_t);

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
		logic [ZW-1:0] r;
		unique case (idx)
			5'd0:    r = 32'd536870912;
			5'd1:    r = 32'd316933406;
			5'd2:    r = 32'd167458907;
			5'd3:    r = 32'd85004756;
			5'd4:    r = 32'd42667331;
			5'd5:    r = 32'd21354465;
			5'd6:    r = 32'd10679838;
			5'd7:    r = 32'd5340245;
			5'd8:    r = 32'd2670163;
			5'd9:    r = 32'd1335087;
			5'd10:   r = 32'd667544;
			5'd11:   r = 32'd333772;
			5'd12:   r = 32'd166886;
			5'd13:   r = 32'd83443;
			5'd14:   r = 32'd41722;
			5'd15:   r = 32'd20861;
			5'd16:   r = 32'd10430;
			5'd17:   r = 32'd5215;
			5'd18:   r = 32'd2608;
			5'd19:   r = 32'd1304;
			5'd20:   r = 32'd652;
			5'd21:   r = 32'd326;
			5'd22:   r = 32'd163;
			5'd23:   r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/tsps_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsps_fifo: small synchronous queue
// Register-based first-in first-out buffer; head is shown while not empty.
// DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module tsps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* design/tsps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsps_front: request intake and vector setup
// Forms x = (2a-b-c)*2^14 and y = (b-c)*sqrt3 in Q.14, flags the all-zero
// case and turns a left-half vector by a half circle.
// ----------------------------------------------------------------------------
module tsps_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tsps_pkg::SAMPLE_W-1:0] sample_a,
	input  logic [tsps_pkg::SAMPLE_W-1:0] sample_b,
	input  logic [tsps_pkg::SAMPLE_W-1:0] sample_c,
	output logic                          item_valid,
	output tsps_pkg::front_item_t         item,
	input  logic                          item_full
);

	import tsps_pkg::*;

	logic signed [10:0] den;
	logic signed [8:0]  dif;
	logic signed [24:0] prod;
	logic signed [XW-1:0] x_raw;
	logic signed [XW-1:0] y_raw;
	front_item_t        nxt;
	logic               adv;
	logic               v_s1;
	front_item_t        item_s1;

	// numerator and denominator terms
	always_comb begin
		den   = signed'({2'b00, sample_a, 1'b0}) - signed'({3'b000, sample_b})
			- signed'({3'b000, sample_c});
		dif   = signed'({1'b0, sample_b}) - signed'({1'b0, sample_c});
		prod  = signed'({{16{dif[8]}}, dif}) * signed'({9'b0, SQRT3_Q14});
		x_raw = {{(XW - 25){den[10]}}, den, 14'b0};
		y_raw = {{(XW - 25){prod[24]}}, prod};
	end

	// half-turn pre-rotation for a negative denominator
	always_comb begin
		nxt.zero = (den == '0) && (dif == '0);
		nxt.half = den[10];
		if (den[10]) begin
			nxt.x = -x_raw;
			nxt.y = -y_raw;
		end else begin
			nxt.x = x_raw;
			nxt.y = y_raw;
		end
	end

	assign adv        = !v_s1 || !item_full;
	assign full       = !adv;
	assign item_valid = v_s1;
	assign item       = item_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			item_s1 <= nxt;
		end
	end

endmodule

/* design/tsps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsps_back: pipelined vectoring cordic
// One micro-rotation per stage drives y to zero while the angle accumulates;
// the last stage rounds the angle to ANGLE_BITS and hands it to the result
// queue. The whole pipe holds while the result queue is full.
// ----------------------------------------------------------------------------
module tsps_back #(
	parameter int ANGLE_BITS   = tsps_pkg::DEF_ANGLE_BITS,
	parameter int CORDIC_STEPS = tsps_pkg::DEF_CORDIC_STEPS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_empty,
	input  tsps_pkg::front_item_t        item,
	output logic                         item_pop,
	output logic                         res_push,
	output logic [tsps_pkg::PHASE_W-1:0] res_phase,
	input  logic                         res_full
);

	import tsps_pkg::*;

	localparam int NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam logic [ZW-1:0] RND = ZW'(1) << (ZW - 1 - ANGLE_BITS);

	logic                 en;
	logic [NS-1:0]        v_s;
	logic signed [XW-1:0] x_s [0:NS-1];
	logic signed [XW-1:0] y_s [0:NS-1];
	logic [ZW-1:0]        z_s [0:NS-1];
	logic                 zero_s [0:NS-1];
	logic [ZW-1:0]        z_rnd;
	logic [ZW-1:0]        z_sh;

	assign en       = !res_full;
	assign item_pop = en && !item_empty;
	assign res_push = en && v_s[NS-1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-2:0], !item_empty};
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic [ZW-1:0]        zi;
		logic                 zeroi;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;

		if (k == 0) begin : g_src_head
			assign xi    = item.x;
			assign yi    = item.y;
			assign zi    = item.half ? HALF_TURN : '0;
			assign zeroi = item.zero;
		end else begin : g_src_prev
			assign xi    = x_s[k-1];
			assign yi    = y_s[k-1];
			assign zi    = z_s[k-1];
			assign zeroi = zero_s[k-1];
		end

		assign dx = yi >>> k;
		assign dy = xi >>> k;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k] <= zeroi;
				if (!yi[XW-1]) begin
					x_s[k] <= xi + dx;
					y_s[k] <= yi - dy;
					z_s[k] <= zi + atan_turn(5'(k));
				end else begin
					x_s[k] <= xi - dx;
					y_s[k] <= yi + dy;
					z_s[k] <= zi - atan_turn(5'(k));
				end
			end
		end
	end

	// round half up to ANGLE_BITS, full turn wraps to zero
	always_comb begin
		z_rnd = z_s[NS-1] + RND;
		z_sh  = z_rnd >> (ZW - ANGLE_BITS);
		res_phase = zero_s[NS-1] ? '0 : z_sh[PHASE_W-1:0];
	end

endmodule

/* design/three_step_phase_shift.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_step_phase_shift: wrapped phase from three fringe samples
// Takes one pixel's three intensities (0, 120 and 240 degree patterns) and
// returns atan2(sqrt3*(b-c), 2a-b-c) in [0, 2pi) as a binary angle.
//
// Input channel: a request is taken on a rising edge with push high and
// full low; sample_a, sample_b and sample_c are sampled there.
// Result channel: while empty is low, angle holds the oldest result;
// it is taken on a rising edge with pop high.
// Throughput: one request per clock when the receiver pops every clock.
// Path: the front register loads on the accepting edge; the result then
// passes the two-entry middle queue, one register per cordic stage and
// the two-entry result queue before it is shown.
// Stall: when the result queue fills, the cordic pipe holds, the middle
// queue fills, and full rises; nothing is dropped.
// Reset: arst_n clears all valid bits and queue counts; empty is high and
// full low right after reset.
// ----------------------------------------------------------------------------
module three_step_phase_shift #(
	parameter int ANGLE_BITS   = tsps_pkg::DEF_ANGLE_BITS,
	parameter int CORDIC_STEPS = tsps_pkg::DEF_CORDIC_STEPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tsps_pkg::SAMPLE_W-1:0] sample_a,
	input  logic [tsps_pkg::SAMPLE_W-1:0] sample_b,
	input  logic [tsps_pkg::SAMPLE_W-1:0] sample_c,
	output logic                          empty,
	input  logic                          pop,
	output logic [tsps_pkg::PHASE_W-1:0]  angle
);

	import tsps_pkg::*;

	logic            mid_push;
	logic            mid_full;
	logic            mid_empty;
	logic            mid_pop;
	front_item_t     mid_in;
	logic [ITEM_W-1:0] mid_out;
	front_item_t     mid_head;
	logic            res_push;
	logic            res_full;
	logic [PHASE_W-1:0] res_phase;

	// front end: intake and vector setup
	tsps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.sample_c   (sample_c),
		.item_valid (mid_push),
		.item       (mid_in),
		.item_full  (mid_full)
	);

	// queue between front and back
	tsps_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty)
	);

	assign mid_head = front_item_t'(mid_out);

	// back end: cordic pipe
	tsps_back #(
		.ANGLE_BITS   (ANGLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_empty (mid_empty),
		.item       (mid_head),
		.item_pop   (mid_pop),
		.res_push   (res_push),
		.res_phase  (res_phase),
		.res_full   (res_full)
	);

	// result queue
	tsps_fifo #(
		.WIDTH (PHASE_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_phase),
		.full   (res_full),
		.pop    (pop),
		.rdata  (angle),
		.empty  (empty)
	);

`ifndef ASSERT_OFF
	// the back end never pops an empty middle queue
	assert property (@(posedge clk) disable iff (!arst_n) mid_pop |-> !mid_empty)
		else $error("middle queue underflow");

	// the cordic pipe never writes into a full result queue
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result queue overflow");

	// intake stalls only when the middle queue is backed up
	assert property (@(posedge clk) disable iff (!arst_n) full |-> mid_full && mid_push)
		else $error("intake stalled with room downstream");

	// a stalled result queue keeps the cordic pipe from draining the middle queue
	assert property (@(posedge clk) disable iff (!arst_n) res_full |-> !mid_pop)
		else $error("middle queue popped while back end held");
`endif

endmodule

/* test/tb_three_step_phase_shift.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_step_phase_shift: self-checking bench for the fringe phase block
// Drives pixel triples through the push/full side and pops phases from the
// empty/pop side, both with random stalls. Each accepted request gets its
// expected phase from a bit-exact CORDIC predictor (or a typed-in value for
// the trivial rows of the directed table). Results are checked in order.
// ----------------------------------------------------------------------------
module tb_three_step_phase_shift;

	localparam int SW = tsps_pkg::SAMPLE_W;
	localparam int PW = tsps_pkg::PHASE_W;

	localparam int ANG_BITS     = 16;
	localparam int N_STEPS      = 16;
	localparam int N_RANDOM     = 1530;
	localparam int CALM_TAIL    = 150;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int PAUSE_AT     = 900;
	localparam int DRAIN_CYCLES = 2 * (N_STEPS + 3) + 10;
	localparam int CYCLE_LIMIT  = 200000;

	// sqrt3 in Q1.14 and 1.0 in Q.14
	localparam longint SQRT3_FX = 28378;
	localparam longint ONE_FX   = 16384;

	// atan(2^-i) in 2^-32 turn units
	localparam logic [31:0] ARCTAN_TURN [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam int CORNER_VALS [9] = '{0, 1, 2, 127, 128, 129, 253, 254, 255};

	typedef struct packed {
		logic [SW-1:0] a;
		logic [SW-1:0] b;
		logic [SW-1:0] c;
		logic          known;
		logic [PW-1:0] phase;
	} pixel_row_t;

	// directed rows; phase typed in only where both terms vanish
	localparam int N_DIRECTED = 22;
	localparam pixel_row_t DIRECTED [N_DIRECTED] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, 16'd0},
		'{8'd255, 8'd255, 8'd255, 1'b1, 16'd0},
		'{8'd128, 8'd128, 8'd128, 1'b1, 16'd0},
		'{8'd1,   8'd1,   8'd1,   1'b1, 16'd0},
		'{8'd255, 8'd0,   8'd0,   1'b0, 16'd0},
		'{8'd0,   8'd255, 8'd255, 1'b0, 16'd0},
		'{8'd0,   8'd255, 8'd0,   1'b0, 16'd0},
		'{8'd0,   8'd0,   8'd255, 1'b0, 16'd0},
		'{8'd255, 8'd255, 8'd0,   1'b0, 16'd0},
		'{8'd255, 8'd0,   8'd255, 1'b0, 16'd0},
		'{8'd128, 8'd255, 8'd1,   1'b0, 16'd0},
		'{8'd128, 8'd1,   8'd255, 1'b0, 16'd0},
		'{8'd0,   8'd1,   8'd0,   1'b0, 16'd0},
		'{8'd0,   8'd0,   8'd1,   1'b0, 16'd0},
		'{8'd1,   8'd0,   8'd0,   1'b0, 16'd0},
		'{8'd0,   8'd1,   8'd1,   1'b0, 16'd0},
		'{8'd127, 8'd128, 8'd128, 1'b0, 16'd0},
		'{8'd128, 8'd127, 8'd127, 1'b0, 16'd0},
		'{8'd170, 8'd85,  8'd255, 1'b0, 16'd0},
		'{8'hAA,  8'h55,  8'hAA,  1'b0, 16'd0},
		'{8'h55,  8'hAA,  8'h55,  1'b0, 16'd0},
		'{8'd255, 8'd0,   8'd128, 1'b0, 16'd0}
	};

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          push     = 1'b0;
	logic          pop      = 1'b0;
	logic [SW-1:0] sample_a = '0;
	logic [SW-1:0] sample_b = '0;
	logic [SW-1:0] sample_c = '0;
	logic          full;
	logic          empty;
	logic [PW-1:0] angle;

	logic [PW-1:0] phase_due [$];
	logic [PW-1:0] oldest_phase;
	int            n_err      = 0;
	int            n_accepted = 0;
	int            n_cycles   = 0;
	bit            calm       = 1'b0;
	bit            hold_done  = 1'b0;

	three_step_phase_shift #(
		.ANGLE_BITS   (ANG_BITS),
		.CORDIC_STEPS (N_STEPS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.sample_c (sample_c),
		.empty    (empty),
		.pop      (pop),
		.angle    (angle)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// wrapped phase of one pixel via vectoring cordic in q.14
	function automatic logic [PW-1:0] fringe_phase(input logic [SW-1:0] a,
		input logic [SW-1:0] b, input logic [SW-1:0] c);
		longint      x;
		longint      y;
		longint      dx;
		longint      dy;
		logic [31:0] z;
		logic [63:0] rounded;
		int          i;
		x = (2 * longint'(a) - longint'(b) - longint'(c)) * ONE_FX;
		y = (longint'(b) - longint'(c)) * SQRT3_FX;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		// left half plane: turn by half a circle first
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (i = 0; i < N_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ARCTAN_TURN[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ARCTAN_TURN[i];
			end
		end
		// round half up to the output angle, full turn wraps to zero
		rounded = {32'd0, z} + (64'd1 << (31 - ANG_BITS));
		rounded = rounded >> (32 - ANG_BITS);
		rounded &= (64'd1 << ANG_BITS) - 64'd1;
		return rounded[PW-1:0];
	endfunction

	function automatic logic [SW-1:0] clamp_sample(input int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return 8'd255;
		return v[SW-1:0];
	endfunction

	// random pixel: fringe triples, uniform triples, axis cases, tiny vectors and corners
	task automatic pick_triple(output logic [SW-1:0] a, output logic [SW-1:0] b,
		output logic [SW-1:0] c);
		int  kind;
		int  bias;
		int  amp;
		int  base;
		int  v [3];
		real phi;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				bias = $urandom_range(1, 254);
				amp  = $urandom_range(0, (bias < 255 - bias) ? bias : 255 - bias);
				phi  = $urandom_range(0, 65535) * 6.283185307179586 / 65536.0;
				for (int k = 0; k < 3; k++)
					v[k] = $rtoi(bias + amp * $cos(phi - k * 2.0943951023931953) + 0.5)
						+ $urandom_range(0, 4) - 2;
				a = clamp_sample(v[0]);
				b = clamp_sample(v[1]);
				c = clamp_sample(v[2]);
			end
			4, 5: begin
				a = SW'($urandom_range(0, 255));
				b = SW'($urandom_range(0, 255));
				c = SW'($urandom_range(0, 255));
			end
			6: begin
				// numerator zero
				a = SW'($urandom_range(0, 255));
				b = SW'($urandom_range(0, 255));
				c = b;
			end
			7: begin
				// denominator zero
				b = SW'($urandom_range(0, 255));
				c = SW'($urandom_range(0, 255));
				if ((b[0] ^ c[0]) == 1'b1)
					c[0] = ~c[0];
				a = SW'((9'(b) + 9'(c)) >> 1);
			end
			8: begin
				// tiny vectors near the origin
				base = $urandom_range(2, 253);
				a = SW'(base + $urandom_range(0, 4) - 2);
				b = SW'(base + $urandom_range(0, 4) - 2);
				c = SW'(base + $urandom_range(0, 4) - 2);
			end
			default: begin
				a = SW'(CORNER_VALS[$urandom_range(0, 8)]);
				b = SW'(CORNER_VALS[$urandom_range(0, 8)]);
				c = SW'(CORNER_VALS[$urandom_range(0, 8)]);
			end
		endcase
	endtask

	// offer one request, wait for it to be taken, record its phase
	task automatic offer(input logic [SW-1:0] a, input logic [SW-1:0] b,
		input logic [SW-1:0] c, input logic known, input logic [PW-1:0] phase);
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		push     <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		sample_c <= c;
		do
			@(posedge clk);
		while (full);
		phase_due = {phase_due, (known ? phase : fringe_phase(a, b, c))};
		n_accepted++;
		@(negedge clk);
	endtask

	// sender: reset, directed table, then random pixels
	initial begin
		logic [SW-1:0] a;
		logic [SW-1:0] b;
		logic [SW-1:0] c;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int r = 0; r < N_DIRECTED; r++)
			offer(DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].c, DIRECTED[r].known,
				DIRECTED[r].phase);
		for (int n = 0; n < N_RANDOM; n++) begin
			// let the block drain completely once
			if (n == PAUSE_AT) begin
				push <= 1'b0;
				@(negedge clk);
				while (phase_due.size() != 0)
					@(negedge clk);
			end
			if (n == N_RANDOM - CALM_TAIL)
				calm = 1'b1;
			pick_triple(a, b, c);
			offer(a, b, c, 1'b0, '0);
		end
		push <= 1'b0;
		while (phase_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_err == 0)
			$display("tb_three_step_phase_shift: done, clean");
		else
			$display("tb_three_step_phase_shift: done, errors");
		$finish;
	end

	// receiver: random pop stalls, one long hold-off to fill the block
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_done && n_accepted >= HOLD_AT) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				pop <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end
		end
	end

	// compare each popped phase with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (phase_due.size() == 0) begin
				$error("angle: expected none, actual %0d", angle);
				n_err++;
			end else begin
				oldest_phase = phase_due.pop_front();
				if (angle !== oldest_phase) begin
					$error("angle: expected %0d, actual %0d", oldest_phase, angle);
					n_err++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("tb_three_step_phase_shift: done, errors");
			$finish;
		end
	end

endmodule

/* sim.f */
design/tsps_pkg.sv
design/tsps_fifo.sv
design/tsps_front.sv
design/tsps_back.sv
design/three_step_phase_shift.sv
test/tb_three_step_phase_shift.sv
